### design/assert_macros.svh
// assertion macros used by sphere_box_pushout
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBP_ASSERT_SAME(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
	else $error("sphere_box_pushout: same-cycle check failed");
`define SBP_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
	else $error("sphere_box_pushout: next-cycle check failed");
`else
`define SBP_ASSERT_SAME(label, cond, prop)
`define SBP_ASSERT_NEXT(label, cond, prop)
`endif
`endif

### design/sbp_pkg.sv
// types, constants and step functions of the sphere box pushout pipeline
package sbp_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int EPS_RAW = ((2 ** FB) + 5000) / 10000;

	// fields that ride along the whole pipe
	typedef struct packed {
		logic                   hit;
		logic [2:0]             neg;
		logic                   sx_gt;
		logic [CW-2:0]          r;
		logic [2:0][CW-1:0]     b;
		logic [2:0][CW-2:0]     ad;
	} carry_t;

	typedef struct packed {
		carry_t          c;
		logic [2*CW-1:0] rad;
		logic [CW+1:0]   rem;
		logic [CW-1:0]   root;
	} sqrt_t;

	typedef struct packed {
		carry_t             c;
		logic               eps_ok;
		logic [CW-1:0]      dvsr;
		logic [2:0][CW-1:0] rem;
		logic [2:0][CW-2:0] num;
		logic [2:0][CW-2:0] q;
	} div_t;

	// one root bit per step
	function automatic sqrt_t sqrt_step(sqrt_t a);
		sqrt_t        o;
		logic [CW+3:0] sh;
		logic [CW+3:0] trial;
		o = a;
		sh = {a.rem, a.rad[2*CW-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		o.rad = {a.rad[2*CW-3:0], 2'b00};
		if (sh >= trial) begin
			o.rem = CW'(0) | (CW+2)'(sh - trial);
			o.root = {a.root[CW-2:0], 1'b1};
		end else begin
			o.rem = sh[CW+1:0];
			o.root = {a.root[CW-2:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit per step on each axis
	function automatic div_t div_step(div_t a);
		div_t        o;
		logic [CW:0] sh;
		o = a;
		for (int i = 0; i < 3; i++) begin
			sh = {a.rem[i], a.num[i][CW-2]};
			o.num[i] = {a.num[i][CW-3:0], 1'b0};
			if (sh >= {1'b0, a.dvsr}) begin
				o.rem[i] = CW'(sh - {1'b0, a.dvsr});
				o.q[i] = {a.q[i][CW-3:0], 1'b1};
			end else begin
				o.rem[i] = sh[CW-1:0];
				o.q[i] = {a.q[i][CW-3:0], 1'b0};
			end
		end
		return o;
	endfunction

	// saturate a value one bit wider than a coordinate
	function automatic logic [CW-1:0] sat1(logic [CW:0] v);
		logic [CW-1:0] o;
		if (v[CW] != v[CW-1]) begin
			o = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			o = v[CW-1:0];
		end
		return o;
	endfunction

endpackage

### design/sbp_if.sv
// handshake channels for test items and results
interface sbp_in_if;
	import sbp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] sphere_x;
	logic signed [CW-1:0] sphere_y;
	logic signed [CW-1:0] sphere_z;
	logic [CW-2:0]        sphere_radius;
	logic signed [CW-1:0] box_x;
	logic signed [CW-1:0] box_y;
	logic signed [CW-1:0] box_z;
	logic [CW-2:0]        half_x;
	logic [CW-2:0]        half_y;
	logic [CW-2:0]        half_z;
	modport source (output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
		box_x, box_y, box_z, half_x, half_y, half_z, input ready);
	modport sink (input valid, sphere_x, sphere_y, sphere_z, sphere_radius,
		box_x, box_y, box_z, half_x, half_y, half_z, output ready);
endinterface

interface sbp_out_if;
	import sbp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic signed [CW-1:0] new_box_x;
	logic signed [CW-1:0] new_box_y;
	logic signed [CW-1:0] new_box_z;
	modport source (output valid, hit, new_box_x, new_box_y, new_box_z, input ready);
	modport sink (input valid, hit, new_box_x, new_box_y, new_box_z, output ready);
endinterface

### design/sphere_box_pushout.sv
// sphere against box collision resolution pipeline, top level
//
// usage: each word on the item channel holds a sphere (center, radius) and a
// box (center, half sizes) in signed q16.16; each word on the result channel
// gives the hit flag and the resolved box center, one result per item, in order
// pipeline: clamp, abs and range check, squares, distance sum and compare,
// one stage per root bit of the integer square root (CW stages), push,
// offset times push, one stage per quotient bit of the three divides
// (CW-1 stages), then the add and saturate into the output register
// throughput: one word per cycle while no stall holds the pipe, set by the
// bit-per-stage root and divide
// stall: the whole pipe holds while the output register is full and the
// receiver is not ready; item.ready drops only then, nothing is lost
// reset: arst_n clears every valid bit at once, the pipe comes up empty
// and takes an item in the first cycle after reset is released
module sphere_box_pushout import sbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sbp_in_if.sink      item,
	sbp_out_if.source   result
);

`include "assert_macros.svh"

	logic adv;

	// stage 1: clamp center into the box
	logic                     vld_s1;
	logic [2:0][CW+1:0]       d_s1;
	logic [2:0][CW-1:0]       b_s1;
	logic [CW-2:0]            r_s1;
	logic                     sxgt_s1;

	// stage 2: magnitudes, early range check
	logic                     vld_s2;
	carry_t                   c_s2;

	// stage 3: squares
	logic                     vld_s3;
	carry_t                   c_s3;
	logic [2:0][2*CW-3:0]     sq_s3;
	logic [2*CW-3:0]          rsq_s3;

	// stage 4: distance squared and hit
	logic                     vld_s4;
	carry_t                   c_s4;
	logic [2*CW-1:0]          dsq_s4;

	// root stages
	sqrt_t                    sqr_s [CW];
	logic                     sqr_vld_s [CW];

	// stage 5: push
	logic                     vld_s5;
	carry_t                   c_s5;
	logic [CW-1:0]            dist_s5;
	logic [CW-2:0]            push_s5;
	logic                     eps_s5;

	// stage 6: offset times push
	logic                     vld_s6;
	carry_t                   c_s6;
	logic [CW-1:0]            dist_s6;
	logic                     eps_s6;
	logic [2:0][2*CW-3:0]     prod_s6;

	// divide stages
	div_t                     div_s [CW-1];
	logic                     div_vld_s [CW-1];

	// output register
	logic                     vld_out_q;
	logic                     hit_q;
	logic [2:0][CW-1:0]       nb_q;

	assign adv = !vld_out_q || result.ready;
	assign item.ready = adv;

	// ---- stage 1 ----
	logic [2:0][CW-1:0] s_in, b_in;
	logic [2:0][CW-2:0] h_in;
	logic [2:0][CW+1:0] d_c;

	assign s_in = {item.sphere_z, item.sphere_y, item.sphere_x};
	assign b_in = {item.box_z, item.box_y, item.box_x};
	assign h_in = {item.half_z, item.half_y, item.half_x};

	always_comb begin
		logic signed [CW:0] lo, hi, sx, cmin, cc;
		for (int i = 0; i < 3; i++) begin
			sx = $signed({s_in[i][CW-1], s_in[i]});
			lo = $signed({b_in[i][CW-1], b_in[i]}) - $signed({2'b00, h_in[i]});
			hi = $signed({b_in[i][CW-1], b_in[i]}) + $signed({2'b00, h_in[i]});
			cmin = (sx < hi) ? sx : hi;
			cc = (cmin < lo) ? lo : cmin;
			d_c[i] = {sx[CW], sx} - {cc[CW], cc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= d_c;
			b_s1 <= b_in;
			r_s1 <= item.sphere_radius;
			sxgt_s1 <= $signed(item.sphere_x) > $signed(item.box_x);
		end
	end

	// ---- stage 2 ----
	carry_t c2_c;
	always_comb begin
		logic [CW+1:0] ad;
		c2_c = '0;
		c2_c.hit = 1'b1;
		c2_c.sx_gt = sxgt_s1;
		c2_c.r = r_s1;
		c2_c.b = b_s1;
		for (int i = 0; i < 3; i++) begin
			c2_c.neg[i] = d_s1[i][CW+1];
			ad = d_s1[i][CW+1] ? (CW+2)'(-d_s1[i]) : d_s1[i];
			if (ad > {3'b000, r_s1}) begin
				c2_c.hit = 1'b0;
			end
			c2_c.ad[i] = ad[CW-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2 <= c2_c;
		end
	end

	// ---- stage 3 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3 <= c_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= c_s2.ad[i] * c_s2.ad[i];
			end
			rsq_s3 <= c_s2.r * c_s2.r;
		end
	end

	// ---- stage 4 ----
	logic [2*CW-1:0] dsq_c;
	carry_t          c4_c;
	assign dsq_c = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};

	always_comb begin
		c4_c = c_s3;
		c4_c.hit = c_s3.hit && !(dsq_c > {2'b00, rsq_s3});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4 <= c4_c;
			dsq_s4 <= dsq_c;
		end
	end

	// ---- square root, one bit per stage ----
	for (genvar k = 0; k < CW; k++) begin : g_sqrt
		sqrt_t in_c;
		logic  in_vld;
		if (k == 0) begin : g_first
			assign in_c = '{c: c_s4, rad: dsq_s4, rem: '0, root: '0};
			assign in_vld = vld_s4;
		end else begin : g_next
			assign in_c = sqr_s[k-1];
			assign in_vld = sqr_vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqr_vld_s[k] <= 1'b0;
			end else if (adv) begin
				sqr_vld_s[k] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqr_s[k] <= sqrt_step(in_c);
			end
		end
	end

	// ---- stage 5: push length ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= sqr_vld_s[CW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s5 <= sqr_s[CW-1].c;
			dist_s5 <= sqr_s[CW-1].root;
			push_s5 <= sqr_s[CW-1].c.r - sqr_s[CW-1].root[CW-2:0];
			eps_s5 <= sqr_s[CW-1].root > CW'(EPS_RAW);
		end
	end

	// ---- stage 6: offset times push ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s6 <= c_s5;
			dist_s6 <= dist_s5;
			eps_s6 <= eps_s5;
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= c_s5.ad[i] * push_s5;
			end
		end
	end

	// ---- divide by distance, one quotient bit per stage ----
	// the quotient never exceeds the push, so the top half starts as remainder
	div_t div_init;
	always_comb begin
		div_init.c = c_s6;
		div_init.eps_ok = eps_s6;
		div_init.dvsr = dist_s6;
		for (int i = 0; i < 3; i++) begin
			div_init.rem[i] = {1'b0, prod_s6[i][2*CW-3:CW-1]};
			div_init.num[i] = prod_s6[i][CW-2:0];
			div_init.q[i] = '0;
		end
	end

	for (genvar k = 0; k < CW-1; k++) begin : g_div
		div_t in_c;
		logic in_vld;
		if (k == 0) begin : g_first
			assign in_c = div_init;
			assign in_vld = vld_s6;
		end else begin : g_next
			assign in_c = div_s[k-1];
			assign in_vld = div_vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (adv) begin
				div_vld_s[k] <= in_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_step(in_c);
			end
		end
	end

	// ---- final move and saturate ----
	div_t               fin;
	logic [2:0][CW-1:0] nb_c;
	assign fin = div_s[CW-2];

	always_comb begin
		logic [CW:0] bx, mv, rr;
		for (int i = 0; i < 3; i++) begin
			bx = {fin.c.b[i][CW-1], fin.c.b[i]};
			mv = {2'b00, fin.q[i]};
			nb_c[i] = fin.c.b[i];
			if (fin.c.hit && fin.eps_ok) begin
				nb_c[i] = sat1(fin.c.neg[i] ? bx + mv : bx - mv);
			end
		end
		bx = {fin.c.b[0][CW-1], fin.c.b[0]};
		rr = {2'b00, fin.c.r};
		if (fin.c.hit && !fin.eps_ok) begin
			// center on the box: push along x away from the sphere
			nb_c[0] = sat1(fin.c.sx_gt ? bx - rr : bx + rr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= div_vld_s[CW-2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= fin.c.hit;
			nb_q <= nb_c;
		end
	end

	assign result.valid = vld_out_q;
	assign result.hit = hit_q;
	assign result.new_box_x = nb_q[0];
	assign result.new_box_y = nb_q[1];
	assign result.new_box_z = nb_q[2];

	// an accepted word shows up in the first stage
	`SBP_ASSERT_NEXT(a_enter, item.valid && item.ready, vld_s1)
	// a stall freezes the valid bits of stage 4 and of the last divide stage
	`SBP_ASSERT_NEXT(a_hold, !adv, $stable(div_vld_s[CW-2]) && $stable(vld_s4))
	// a hit after the distance compare needs a hit before it
	`SBP_ASSERT_NEXT(a_hit, adv && vld_s3 && !c_s3.hit, !c_s4.hit)

endmodule
